@@ design/tgr_pkg.sv @@
// Shared types, constants and font table for the text glyph rasterizer.
// No dependencies; used by tgr_front, tgr_back and the top level by scoped names.

package tgr_pkg;

    localparam int GLYPH_COUNT = 43;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = 6;
    localparam int ROW_BITS    = 3;
    localparam int COL_BITS    = 3;
    localparam int DIM_BITS    = 11;
    localparam int ADDR_BITS   = 22;
    localparam int COLOR_BITS  = 16;
    localparam int CODE_BITS   = 8;
    localparam int START_BITS  = 12;
    localparam int WIDE_BITS   = 17;
    localparam int CHAR_ADVANCE = 6;

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 1'b1;
    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = 11'd160;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 11'd120;

    localparam logic [ROW_BITS-1:0] ROW_LAST = 3'(GLYPH_ROWS - 1);
    localparam logic [COL_BITS-1:0] COL_LAST = 3'(GLYPH_COLS - 1);

    typedef struct packed {
        logic                  known;
        logic [GLYPH_BITS-1:0] idx;
    } glyph_sel_t;

    // row words, bit 0 is the leftmost pixel; only bits 0..4 are shown
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h18,8'h18},
        '{8'h00,8'h00,8'h00,8'h3C,8'h00,8'h00,8'h00},
        '{8'h00,8'h18,8'h18,8'h00,8'h18,8'h18,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20,8'h00,8'h00},
        '{8'h00,8'h00,8'h3C,8'h00,8'h3C,8'h00,8'h00},
        '{8'h20,8'h10,8'h08,8'h04,8'h08,8'h10,8'h20},
        '{8'h1C,8'h22,8'h51,8'h51,8'h51,8'h22,8'h1C},
        '{8'h04,8'h0C,8'h04,8'h04,8'h04,8'h04,8'h1C},
        '{8'h1C,8'h22,8'h02,8'h04,8'h08,8'h10,8'h3E},
        '{8'h1C,8'h22,8'h02,8'h1C,8'h02,8'h22,8'h1C},
        '{8'h02,8'h06,8'h0A,8'h12,8'h3E,8'h02,8'h02},
        '{8'h3E,8'h20,8'h3C,8'h02,8'h02,8'h22,8'h1C},
        '{8'h0C,8'h10,8'h20,8'h3C,8'h22,8'h22,8'h1C},
        '{8'h3E,8'h02,8'h04,8'h08,8'h10,8'h10,8'h10},
        '{8'h1C,8'h22,8'h22,8'h1C,8'h22,8'h22,8'h1C},
        '{8'h1C,8'h22,8'h22,8'h1E,8'h02,8'h0C,8'h18},
        '{8'h1C,8'h22,8'h22,8'h3E,8'h22,8'h22,8'h22},
        '{8'h3C,8'h22,8'h22,8'h3C,8'h22,8'h22,8'h3C},
        '{8'h1C,8'h22,8'h20,8'h20,8'h20,8'h22,8'h1C},
        '{8'h3C,8'h22,8'h22,8'h22,8'h22,8'h22,8'h3C},
        '{8'h3E,8'h20,8'h20,8'h3C,8'h20,8'h20,8'h3E},
        '{8'h3E,8'h20,8'h20,8'h3C,8'h20,8'h20,8'h20},
        '{8'h1C,8'h22,8'h20,8'h2E,8'h22,8'h22,8'h1E},
        '{8'h22,8'h22,8'h22,8'h3E,8'h22,8'h22,8'h22},
        '{8'h1C,8'h04,8'h04,8'h04,8'h04,8'h04,8'h1C},
        '{8'h38,8'h08,8'h08,8'h08,8'h08,8'h28,8'h10},
        '{8'h22,8'h24,8'h28,8'h30,8'h28,8'h24,8'h22},
        '{8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h3E},
        '{8'h22,8'h36,8'h2A,8'h2A,8'h22,8'h22,8'h22},
        '{8'h22,8'h32,8'h3A,8'h2A,8'h26,8'h22,8'h22},
        '{8'h1C,8'h22,8'h22,8'h22,8'h22,8'h22,8'h1C},
        '{8'h3C,8'h22,8'h22,8'h3C,8'h20,8'h20,8'h20},
        '{8'h1C,8'h22,8'h22,8'h22,8'h26,8'h2A,8'h14},
        '{8'h3C,8'h22,8'h22,8'h3C,8'h28,8'h24,8'h22},
        '{8'h1E,8'h20,8'h20,8'h1C,8'h02,8'h02,8'h3C},
        '{8'h3E,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04},
        '{8'h22,8'h22,8'h22,8'h22,8'h22,8'h22,8'h1C},
        '{8'h22,8'h22,8'h22,8'h22,8'h22,8'h14,8'h08},
        '{8'h22,8'h22,8'h22,8'h2A,8'h2A,8'h36,8'h22},
        '{8'h22,8'h22,8'h14,8'h08,8'h14,8'h22,8'h22},
        '{8'h22,8'h22,8'h22,8'h14,8'h08,8'h08,8'h08},
        '{8'h3E,8'h02,8'h04,8'h08,8'h10,8'h20,8'h3E}
    };

    function automatic glyph_sel_t glyph_of(input logic [CODE_BITS-1:0] code);
        glyph_sel_t sel;
        sel.known = 1'b1;
        sel.idx   = '0;
        priority if (code == 8'h20) sel.idx = 6'd0;
        else if (code == 8'h2E) sel.idx = 6'd1;
        else if (code == 8'h2D) sel.idx = 6'd2;
        else if (code == 8'h3A) sel.idx = 6'd3;
        else if (code == 8'h2F) sel.idx = 6'd4;
        else if (code == 8'h3D) sel.idx = 6'd5;
        else if (code == 8'h3E) sel.idx = 6'd6;
        else if (code >= 8'h30 && code <= 8'h39) sel.idx = 6'(code - 8'h30 + 8'd7);
        else if (code >= 8'h41 && code <= 8'h5A) sel.idx = 6'(code - 8'h41 + 8'd17);
        else if (code >= 8'h61 && code <= 8'h7A) sel.idx = 6'(code - 8'h61 + 8'd17);
        else sel.known = 1'b0;
        return sel;
    endfunction

endpackage

@@ design/tgr_front.sv @@
// Front end: takes character transfers, loads and advances the cursor,
// maps codes to glyphs and hands drawable characters to the job queue.
// Depends on tgr_pkg.

module tgr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [tgr_pkg::CODE_BITS-1:0]          char_code,
    input  logic                                   first_char,
    input  logic signed [tgr_pkg::START_BITS-1:0]  start_x,
    input  logic signed [tgr_pkg::START_BITS-1:0]  start_y,
    input  logic [tgr_pkg::COLOR_BITS-1:0]         text_color,
    input  logic                                   q_full,
    output logic                                   q_push,
    output logic [tgr_pkg::GLYPH_BITS-1:0]         job_glyph,
    output logic signed [COORD_BITS-1:0]           job_col,
    output logic signed [COORD_BITS-1:0]           job_row,
    output logic [tgr_pkg::COLOR_BITS-1:0]         job_color
);

    localparam int W = tgr_pkg::WIDE_BITS;
    localparam logic signed [W-1:0] CMAX = W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] CMIN = -W'(1 << (COORD_BITS - 1));

    logic signed [COORD_BITS-1:0] cursor_col_reg, cursor_col_next;
    logic signed [COORD_BITS-1:0] cursor_row_reg, cursor_row_next;
    logic signed [W-1:0] sx_w, sy_w, adv_w;
    logic signed [COORD_BITS-1:0] sx_sat, sy_sat, cur_col, cur_row;
    tgr_pkg::glyph_sel_t sel;
    logic accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sel      = tgr_pkg::glyph_of(char_code);

    always_comb
    begin
        sx_w = W'(start_x);
        sy_w = W'(start_y);
        priority if (sx_w > CMAX) sx_sat = CMAX[COORD_BITS-1:0];
        else if (sx_w < CMIN) sx_sat = CMIN[COORD_BITS-1:0];
        else sx_sat = sx_w[COORD_BITS-1:0];
        priority if (sy_w > CMAX) sy_sat = CMAX[COORD_BITS-1:0];
        else if (sy_w < CMIN) sy_sat = CMIN[COORD_BITS-1:0];
        else sy_sat = sy_w[COORD_BITS-1:0];

        cur_col = first_char ? sx_sat : cursor_col_reg;
        cur_row = first_char ? sy_sat : cursor_row_reg;

        adv_w = W'(cur_col) + W'(tgr_pkg::CHAR_ADVANCE);
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (accept)
        begin
            cursor_col_next = (adv_w > CMAX) ? CMAX[COORD_BITS-1:0]
                                             : adv_w[COORD_BITS-1:0];
            cursor_row_next = cur_row;
        end
    end

    assign q_push    = accept && sel.known;
    assign job_glyph = sel.idx;
    assign job_col   = cur_col;
    assign job_row   = cur_row;
    assign job_color = text_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

@@ design/tgr_queue.sv @@
// Two-entry job queue between the front end and the glyph scanner.
// Depends on nothing beyond its width parameter.

module tgr_queue #(
    parameter int WIDTH = 46
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/tgr_back.sv @@
// Back end: scans the 5x7 glyph of one queued character and emits one
// pixel transfer per lit in-frame pixel. Depends on tgr_pkg.

module tgr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tgr_pkg::DIM_BITS-1:0]        frame_width,
    input  logic [tgr_pkg::DIM_BITS-1:0]        frame_height,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic [tgr_pkg::GLYPH_BITS-1:0]      job_glyph,
    input  logic signed [COORD_BITS-1:0]        job_col,
    input  logic signed [COORD_BITS-1:0]        job_row,
    input  logic [tgr_pkg::COLOR_BITS-1:0]      job_color,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tgr_pkg::ADDR_BITS-1:0]       pixel_address,
    output logic [tgr_pkg::COLOR_BITS-1:0]      pixel_color,
    output logic                                last_pixel
);

    localparam int W  = tgr_pkg::WIDE_BITS;
    localparam int CW = COORD_BITS + 1;
    localparam int DB = tgr_pkg::DIM_BITS;
    localparam int AB = tgr_pkg::ADDR_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [tgr_pkg::GLYPH_BITS-1:0] glyph_reg, glyph_next;
    logic signed [COORD_BITS-1:0]   col_reg, col_next, row_reg, row_next;
    logic [tgr_pkg::COLOR_BITS-1:0] color_reg, color_next;
    logic [tgr_pkg::ROW_BITS-1:0]   rcnt_reg, rcnt_next;
    logic [tgr_pkg::COL_BITS-1:0]   ccnt_reg, ccnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [AB-1:0]                  pend_addr_reg, pend_addr_next;
    logic                           out_valid_reg, out_valid_next;
    logic [AB-1:0]                  out_addr_reg, out_addr_next;
    logic [tgr_pkg::COLOR_BITS-1:0] out_color_reg, out_color_next;
    logic                           out_last_reg, out_last_next;

    logic [7:0]            row_word;
    logic                  lit, hit, out_free, stall, last_pos;
    logic signed [CW-1:0]  px_s, py_s;
    logic [W-1:0]          px_u, py_u;
    logic [AB-1:0]         addr;

    assign row_word = tgr_pkg::GLYPH_ROM[glyph_reg][rcnt_reg];
    assign lit      = row_word[ccnt_reg];
    assign out_free = !out_valid_reg || out_ready;
    assign last_pos = (rcnt_reg == tgr_pkg::ROW_LAST) && (ccnt_reg == tgr_pkg::COL_LAST);

    always_comb
    begin
        px_s = CW'(col_reg) + CW'(ccnt_reg);
        py_s = CW'(row_reg) + CW'(rcnt_reg);
        px_u = (px_s < 0) ? '0 : W'($unsigned(px_s));
        py_u = (py_s < 0) ? '0 : W'($unsigned(py_s));
        hit  = lit && (px_u < W'(frame_width)) && (py_u < W'(frame_height));
        addr = AB'(py_u[DB-1:0]) * AB'(frame_width) + AB'(px_u[DB-1:0]);
        stall = hit && pend_valid_reg && !out_free;
    end

    always_comb
    begin
        state_next      = state_reg;
        glyph_next      = glyph_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        color_next      = color_reg;
        rcnt_next       = rcnt_reg;
        ccnt_next       = ccnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    glyph_next = job_glyph;
                    col_next   = job_col;
                    row_next   = job_row;
                    color_next = job_color;
                    rcnt_next  = '0;
                    ccnt_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_addr_next  = pend_addr_reg;
                            out_color_next = color_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_addr_next  = addr;
                    end
                    if (last_pos)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (ccnt_reg == tgr_pkg::COL_LAST)
                    begin
                        ccnt_next = '0;
                        rcnt_next = rcnt_reg + 3'd1;
                    end
                    else
                    begin
                        ccnt_next = ccnt_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = pend_addr_reg;
                    out_color_next  = color_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        glyph_reg     <= glyph_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        color_reg     <= color_next;
        rcnt_reg      <= rcnt_next;
        ccnt_reg      <= ccnt_next;
        pend_addr_reg <= pend_addr_next;
        out_addr_reg  <= out_addr_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = out_addr_reg;
    assign pixel_color   = out_color_reg;
    assign last_pixel    = out_last_reg;

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending pixel left behind at end of character");

    a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && (!pend_valid_reg || out_free)) |=> (state_reg == ST_IDLE))
        else $error("closing step did not finish");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (rcnt_reg <= tgr_pkg::ROW_LAST && ccnt_reg <= tgr_pkg::COL_LAST))
        else $error("scan position out of glyph");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE && q_valid))
        else $error("job taken while busy");

endmodule

@@ design/text_glyph_rasterizer.sv @@
// Top level of the text glyph rasterizer: configuration registers, front
// end, job queue and glyph scanner. Depends on tgr_pkg, tgr_front,
// tgr_queue and tgr_back.
//
// Each character transfer is taken by the front end when the queue is not
// full; it loads or advances the cursor at once, and characters with a
// glyph go to a two-entry job queue. The scanner takes one job and walks
// its 35 glyph positions at one position per cycle while the output does
// not stall: it takes the job when idle, scans the 35 positions, then closes
// out and flags the final pixel with tlast. Codes without a glyph emit
// nothing. The pixel address comes from an 11 by 11 multiply of the row
// by frame_width in the scan step.

module text_glyph_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // char_code[7:0], start_x[19:8], start_y[31:20], text_color[47:32]
    input  logic [47:0] s_axis_tdata,
    // first_char
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_address[21:0], pixel_color[37:22], zero[39:38]
    output logic [39:0] m_axis_tdata,
    // last_pixel
    output logic        m_axis_tlast
);

    localparam int JOB_W = tgr_pkg::GLYPH_BITS + 2 * COORD_BITS + tgr_pkg::COLOR_BITS;

    logic [tgr_pkg::DIM_BITS-1:0] frame_width_reg, frame_height_reg;

    logic                                 q_full, q_push, q_pop, q_valid;
    logic [tgr_pkg::GLYPH_BITS-1:0]       f_glyph, b_glyph;
    logic signed [COORD_BITS-1:0]         f_col, f_row, b_col, b_row;
    logic [tgr_pkg::COLOR_BITS-1:0]       f_color, b_color;
    logic [JOB_W-1:0]                     q_in, q_out;
    logic [tgr_pkg::ADDR_BITS-1:0]        pixel_address;
    logic [tgr_pkg::COLOR_BITS-1:0]       pixel_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= tgr_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= tgr_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tgr_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                tgr_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tgr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .char_code  (s_axis_tdata[7:0]),
        .first_char (s_axis_tuser),
        .start_x    ($signed(s_axis_tdata[19:8])),
        .start_y    ($signed(s_axis_tdata[31:20])),
        .text_color (s_axis_tdata[47:32]),
        .q_full     (q_full),
        .q_push     (q_push),
        .job_glyph  (f_glyph),
        .job_col    (f_col),
        .job_row    (f_row),
        .job_color  (f_color)
    );

    assign q_in = {f_color, f_row, f_col, f_glyph};

    tgr_queue #(.WIDTH(JOB_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    assign {b_color, b_row, b_col, b_glyph} = q_out;

    tgr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .job_glyph     (b_glyph),
        .job_col       (b_col),
        .job_row       (b_row),
        .job_color     (b_color),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, pixel_color, pixel_address};

endmodule
